FILE: rtl/core/evad_pkg.sv
package evad_pkg;

    // default sizes handed to the top level parameters
    localparam int RMS_BITS_DEF   = 23;
    localparam int COUNT_BITS_DEF = 16;

    // log2 fraction bits, one squaring stage each
    localparam int FRAC_BITS = 16;

    // normalized mantissa is Q1.31, top bit index of the 33 bit shift window
    localparam int NORM_TOP = 32;

    // round(20*log10(2) * 65536), scales log2 Q16 into dB Q8.8 after DB_SHIFT
    localparam int DB_K_W = 19;
    localparam logic [DB_K_W-1:0] DB_PER_LOG2_Q16 = 19'd394566;
    localparam int DB_SHIFT = 24;
    localparam logic [DB_SHIFT-1:0] DB_ROUND = 24'h800000;
    localparam logic [15:0] DB_MAX = 16'hFFFF;

    // stages inside one log lane: leading one, normalize, squares, dB scale
    localparam int LANE_DEPTH = 2 + FRAC_BITS + 1;
    // last valid bit of the pipeline, aligned with the level register
    localparam int PIPE_LAST  = LANE_DEPTH + 1;

    // 8 bit counter ceiling
    localparam logic [7:0] CNT8_MAX = 8'hFF;

    // result event codes
    localparam logic [1:0] EVT_NONE  = 2'd0;
    localparam logic [1:0] EVT_START = 2'd1;
    localparam logic [1:0] EVT_END   = 2'd2;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_START_THR  = 3'd0,
        REG_ONSET      = 3'd1,
        REG_OFFSET     = 3'd2,
        REG_MIN_SPEECH = 3'd3,
        REG_MAX_SPEECH = 3'd4,
        REG_ALPHA      = 3'd5,
        REG_INIT_NOISE = 3'd6
    } cfg_reg_t;

    // reset values of the configuration registers
    localparam logic [15:0] RST_START_THR  = 16'd2560;
    localparam logic [7:0]  RST_ONSET      = 8'd3;
    localparam logic [7:0]  RST_OFFSET     = 8'd15;
    localparam logic [15:0] RST_MIN_SPEECH = 16'd10;
    localparam logic [15:0] RST_MAX_SPEECH = 16'd500;
    localparam logic [15:0] RST_ALPHA      = 16'd62259;
    localparam logic [15:0] RST_INIT_NOISE = 16'd10240;

    // settings seen by the decision logic
    typedef struct packed {
        logic [15:0] start_threshold_db;
        logic [7:0]  onset_frames;
        logic [7:0]  offset_frames;
        logic [15:0] min_speech_frames;
        logic [15:0] max_speech_frames;
        logic [15:0] noise_alpha;
    } cfg_t;

endpackage

FILE: rtl/core/evad_log_lane.sv
module evad_log_lane #(
    parameter int RMS_BITS = evad_pkg::RMS_BITS_DEF
) (
    input  logic                clk,
    input  logic                advance,
    input  logic [RMS_BITS-1:0] rms,
    output logic [15:0]         db
);
    import evad_pkg::*;

    localparam int V_W = RMS_BITS + 1;
    localparam int E_W = $clog2(V_W);
    localparam int L_W = E_W + FRAC_BITS;
    localparam int P_W = (L_W + DB_K_W > DB_SHIFT + 17) ? (L_W + DB_K_W) : (DB_SHIFT + 17);
    localparam int Q_W = P_W - DB_SHIFT;

    logic [V_W-1:0] v_next;
    logic [E_W-1:0] e_next;
    logic [V_W-1:0] v_a_reg;
    logic [E_W-1:0] e_a_reg;

    logic [5:0]     shamt;
    logic [32:0]    norm;
    logic [31:0]    m_b_reg;
    logic [L_W-1:0] l_b_reg;

    wire  [31:0]    m_pipe [0:FRAC_BITS];
    wire  [L_W-1:0] l_pipe [0:FRAC_BITS];

    logic [P_W-1:0] prod;
    logic [P_W-1:0] rounded;
    logic [Q_W-1:0] scaled;
    logic [15:0]    db_next;
    logic [15:0]    db_reg;

    // rms plus one and position of its top set bit
    always_comb
    begin
        v_next = {1'b0, rms} + V_W'(1);
        e_next = '0;
        for (int i = 0; i < V_W; i++)
        begin
            if (v_next[i])
            begin
                e_next = E_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            v_a_reg <= v_next;
            e_a_reg <= e_next;
        end
    end

    // normalize to Q1.31 with the top bit at bit 31
    always_comb
    begin
        shamt = 6'(NORM_TOP) - 6'(e_a_reg);
        norm  = 33'(v_a_reg) << shamt;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_b_reg <= norm[32:1];
            l_b_reg <= {e_a_reg, {FRAC_BITS{1'b0}}};
        end
    end

    assign m_pipe[0] = m_b_reg;
    assign l_pipe[0] = l_b_reg;

    // one fraction bit per stage, msb first, by repeated squaring
    for (genvar k = 0; k < FRAC_BITS; k++)
    begin : g_sq
        logic [63:0]    sq;
        logic [32:0]    t;
        logic [31:0]    m_next;
        logic [L_W-1:0] l_next;
        logic [31:0]    m_reg;
        logic [L_W-1:0] l_reg;

        always_comb
        begin
            sq = m_pipe[k] * m_pipe[k];
            t  = sq[63:31];
            if (t[32])
            begin
                m_next = t[32:1];
                l_next = l_pipe[k] | (L_W'(1) << (FRAC_BITS - 1 - k));
            end
            else
            begin
                m_next = t[31:0];
                l_next = l_pipe[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                m_reg <= m_next;
                l_reg <= l_next;
            end
        end

        assign m_pipe[k+1] = m_reg;
        assign l_pipe[k+1] = l_reg;
    end

    // scale log2 to dB with rounding and saturation
    always_comb
    begin
        prod    = l_pipe[FRAC_BITS] * DB_PER_LOG2_Q16;
        rounded = prod + P_W'(DB_ROUND);
        scaled  = rounded[P_W-1:DB_SHIFT];
        if (scaled > Q_W'(DB_MAX))
        begin
            db_next = DB_MAX;
        end
        else
        begin
            db_next = scaled[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            db_reg <= db_next;
        end
    end

    assign db = db_reg;

endmodule

FILE: rtl/core/evad_ctrl.sv
module evad_ctrl #(
    parameter int COUNT_BITS = evad_pkg::COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  evad_pkg::cfg_t    cfg,
    input  logic              floor_load,
    input  logic [15:0]       floor_value,
    input  logic              frame_valid_last,
    input  logic [15:0]       db_left,
    input  logic [15:0]       db_right,
    input  logic              result_ready,
    output logic              advance,
    output logic              result_valid,
    output logic [1:0]        event_res,
    output logic [15:0]       level_db,
    output logic              speaking
);
    import evad_pkg::*;

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] SPEECH_MAX = '1;

    logic [15:0]           level_reg;
    logic                  in_speech_reg, in_speech_next;
    logic [15:0]           floor_reg, floor_next;
    logic [7:0]            hit_reg, hit_next;
    logic [7:0]            low_reg, low_next;
    logic [COUNT_BITS-1:0] speech_reg, speech_next;
    logic [1:0]            event_next;

    logic                  result_valid_reg;
    logic [1:0]            event_reg;
    logic [15:0]           level_out_reg;
    logic                  speaking_reg;

    logic [16:0]           start_level;
    logic [16:0]           keep_level;
    logic                  onset_hit;
    logic                  hold_hit;
    logic [7:0]            hit_inc;
    logic [7:0]            low_inc;
    logic [COUNT_BITS-1:0] speech_inc;
    logic signed [16:0]    diff;
    logic signed [33:0]    prod;
    logic signed [34:0]    acc;
    logic                  step;

    // pipeline moves whenever the result register is free or being taken
    assign advance = !result_valid_reg || result_ready;
    assign step    = advance && frame_valid_last;

    // louder channel
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            level_reg <= (db_left > db_right) ? db_left : db_right;
        end
    end

    // thresholds, saturating counters and noise floor average
    always_comb
    begin
        start_level = {1'b0, floor_reg} + {1'b0, cfg.start_threshold_db};
        keep_level  = {1'b0, floor_reg} + {2'b00, cfg.start_threshold_db[15:1]};
        onset_hit   = {1'b0, level_reg} >= start_level;
        hold_hit    = {1'b0, level_reg} >= keep_level;
        hit_inc     = (hit_reg == CNT8_MAX) ? hit_reg : hit_reg + 8'd1;
        low_inc     = (low_reg == CNT8_MAX) ? low_reg : low_reg + 8'd1;
        speech_inc  = (speech_reg == SPEECH_MAX) ? speech_reg
                                                 : speech_reg + COUNT_BITS'(1);
        // alpha*floor + (65536-alpha)*level + half, with one multiply
        diff = $signed({1'b0, floor_reg}) - $signed({1'b0, level_reg});
        prod = $signed({1'b0, cfg.noise_alpha}) * diff;
        acc  = $signed({3'b000, level_reg, 16'h8000}) + 35'(prod);
    end

    // silence / speech decision
    always_comb
    begin
        in_speech_next = in_speech_reg;
        floor_next     = floor_reg;
        hit_next       = hit_reg;
        low_next       = low_reg;
        speech_next    = speech_reg;
        event_next     = EVT_NONE;

        if (!in_speech_reg)
        begin
            if (onset_hit)
            begin
                if (hit_inc >= cfg.onset_frames)
                begin
                    in_speech_next = 1'b1;
                    hit_next       = '0;
                    low_next       = '0;
                    event_next     = EVT_START;
                end
                else
                begin
                    hit_next    = hit_inc;
                    speech_next = speech_inc;
                end
            end
            else
            begin
                speech_next = '0;
                hit_next    = '0;
                floor_next  = acc[31:16];
            end
        end
        else
        begin
            if (hold_hit)
            begin
                speech_next = speech_inc;
                low_next    = '0;
            end
            else if (low_inc >= cfg.offset_frames)
            begin
                in_speech_next = 1'b0;
                low_next       = '0;
                hit_next       = '0;
                if (CMP_W'(speech_reg) >= CMP_W'(cfg.min_speech_frames))
                begin
                    event_next  = EVT_END;
                    speech_next = '0;
                end
            end
            else
            begin
                low_next    = low_inc;
                speech_next = speech_inc;
            end
        end

        // forced end at the maximum length
        if (CMP_W'(speech_next) >= CMP_W'(cfg.max_speech_frames))
        begin
            in_speech_next = 1'b0;
            hit_next       = '0;
            low_next       = '0;
            speech_next    = '0;
            event_next     = EVT_END;
        end
    end

    // detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_speech_reg <= 1'b0;
            floor_reg     <= RST_INIT_NOISE;
            hit_reg       <= '0;
            low_reg       <= '0;
            speech_reg    <= '0;
        end
        else if (floor_load)
        begin
            floor_reg <= floor_value;
        end
        else if (step)
        begin
            in_speech_reg <= in_speech_next;
            floor_reg     <= floor_next;
            hit_reg       <= hit_next;
            low_reg       <= low_next;
            speech_reg    <= speech_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= frame_valid_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            event_reg     <= event_next;
            level_out_reg <= level_reg;
            speaking_reg  <= in_speech_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign event_res    = event_reg;
    assign level_db     = level_out_reg;
    assign speaking     = speaking_reg;

endmodule

FILE: rtl/core/energy_voice_activity_detector.sv
// Energy based voice activity detector, one frame per transaction.
// Frame channel (frame_valid / frame_ready) carries the left and right
// frame RMS levels; result channel (result_valid / result_ready) returns
// one result per frame: event_res (none, speech start, speech end), the
// louder channel level_db in Q8.8 dB and the speaking flag after the frame.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is
// always ready; write it only while no frame is in flight. Writing the
// initial noise register also loads the noise floor at once.
// Path from frame acceptance to result_valid: the input register, the
// log pipeline (leading one, normalize, 16 squaring stages, dB scale),
// the channel max stage and the decision stage that owns the result register.
// Throughput: one frame per cycle while no result stalls; detector state
// updates in the single decision stage, so frames follow back to back.
// Reset clears the pipeline valid bits and the detector state and loads
// the configuration registers with defaults; no result is pending afterwards.
// When the receiver stalls the whole pipeline holds and frame_ready drops
// until the waiting result is taken.
module energy_voice_activity_detector #(
    parameter int RMS_BITS   = evad_pkg::RMS_BITS_DEF,
    parameter int COUNT_BITS = evad_pkg::COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                frame_valid,
    output logic                frame_ready,
    input  logic [RMS_BITS-1:0] rms_left,
    input  logic [RMS_BITS-1:0] rms_right,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [1:0]          event_res,
    output logic [15:0]         level_db,
    output logic                speaking,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import evad_pkg::*;

    cfg_t                cfg_reg;
    logic                floor_load;
    logic                cfg_write;
    logic                advance;
    logic [PIPE_LAST:0]  vld_reg;
    logic [RMS_BITS-1:0] rms_l_reg;
    logic [RMS_BITS-1:0] rms_r_reg;
    logic [15:0]         db_left;
    logic [15:0]         db_right;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign frame_ready = advance;
    assign floor_load  = cfg_write && (cfg_reg_t'(cfg_index) == REG_INIT_NOISE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_threshold_db <= RST_START_THR;
            cfg_reg.onset_frames       <= RST_ONSET;
            cfg_reg.offset_frames      <= RST_OFFSET;
            cfg_reg.min_speech_frames  <= RST_MIN_SPEECH;
            cfg_reg.max_speech_frames  <= RST_MAX_SPEECH;
            cfg_reg.noise_alpha        <= RST_ALPHA;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_START_THR:  cfg_reg.start_threshold_db <= cfg_data;
                REG_ONSET:      cfg_reg.onset_frames       <= cfg_data[7:0];
                REG_OFFSET:     cfg_reg.offset_frames      <= cfg_data[7:0];
                REG_MIN_SPEECH: cfg_reg.min_speech_frames  <= cfg_data;
                REG_MAX_SPEECH: cfg_reg.max_speech_frames  <= cfg_data;
                REG_ALPHA:      cfg_reg.noise_alpha        <= cfg_data;
                REG_INIT_NOISE: ;
                default:        ;
            endcase
        end
    end

    // frame valid bits along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[PIPE_LAST-1:0], frame_valid};
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rms_l_reg <= rms_left;
            rms_r_reg <= rms_right;
        end
    end

    evad_log_lane #(
        .RMS_BITS (RMS_BITS)
    ) u_lane_left (
        .clk     (clk),
        .advance (advance),
        .rms     (rms_l_reg),
        .db      (db_left)
    );

    evad_log_lane #(
        .RMS_BITS (RMS_BITS)
    ) u_lane_right (
        .clk     (clk),
        .advance (advance),
        .rms     (rms_r_reg),
        .db      (db_right)
    );

    evad_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .floor_load       (floor_load),
        .floor_value      (cfg_data),
        .frame_valid_last (vld_reg[PIPE_LAST]),
        .db_left          (db_left),
        .db_right         (db_right),
        .result_ready     (result_ready),
        .advance          (advance),
        .result_valid     (result_valid),
        .event_res        (event_res),
        .level_db         (level_db),
        .speaking         (speaking)
    );

endmodule

FILE: rtl/core/evad_checker.sv
module evad_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        frame_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [1:0]  event_res,
    input logic [15:0] level_db,
    input logic        speaking
);
    import evad_pkg::*;

    // a stalled result holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(event_res)
            && $stable(level_db) && $stable(speaking))
        else $error("result changed while stalled");

    // a waiting result blocks new frames
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !frame_ready)
        else $error("frame accepted while result stalled");

    // start leaves the detector in speech
    a_start_speaking: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && event_res == EVT_START |-> speaking)
        else $error("start event without speech");

    // end leaves the detector in silence
    a_end_silent: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && event_res == EVT_END |-> !speaking)
        else $error("end event while speaking");

    // only defined event codes
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> event_res == EVT_NONE || event_res == EVT_START
            || event_res == EVT_END)
        else $error("undefined event code");

endmodule

bind energy_voice_activity_detector evad_checker u_evad_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_ready  (frame_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .event_res    (event_res),
    .level_db     (level_db),
    .speaking     (speaking)
);
